FILE: src/vpr_pkg.sv
// ----------------------------------------------------------------------------
// vpr_pkg: shared types and constants for the version payload relay check
// Parse phases, relay byte codes, register indexes and field offsets.
// ----------------------------------------------------------------------------
`default_nettype none

package vpr_pkg;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_MIN_PROTO_VERSION   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_RELAY_ONLY    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FEELER_CONN         = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ADDR_FETCH_CONN     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IGNORE_INCOMING_TXS = 3'd4;

  localparam int CfgDataW = 32;
  localparam int MinVerW  = 31;
  localparam logic [MinVerW-1:0] MIN_VERSION_RESET = 31'd70016;

  // Payload layout
  localparam int PosW    = 17;
  localparam int LenW    = 16;
  localparam int VerW    = 32;
  localparam int LenOffset = 4 + 8 + 8 + 26 + 26 + 8;
  localparam logic [PosW-1:0] POS_LAST_HEADER = PosW'(LenOffset - 1);
  localparam logic [PosW-1:0] POS_EXT_LOW     = PosW'(LenOffset + 1);
  localparam logic [PosW-1:0] POS_VER_DONE    = PosW'(4);
  localparam logic [PosW-1:0] POS_MAX         = {PosW{1'b1}};
  localparam logic [LenW-1:0] HEIGHT_LEN      = LenW'(4);

  // Length prefix codes
  localparam logic [7:0] LEN_PREFIX_16 = 8'hfd;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LENGTH = 3'd1,
    PH_EXT    = 3'd2,
    PH_AGENT  = 3'd3,
    PH_HEIGHT = 3'd4,
    PH_RELAY  = 3'd5,
    PH_DONE   = 3'd6,
    PH_BAD    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    RELAY_ABSENT  = 2'd0,
    RELAY_ZERO    = 2'd1,
    RELAY_NONZERO = 2'd2
  } relay_t;

endpackage

`default_nettype wire

FILE: src/version_payload_relay_offer_check.sv
// ----------------------------------------------------------------------------
// version_payload_relay_offer_check
// Walks a peer version payload one byte per word, captures the protocol
// version and relay byte, and reports parse status and the offer decision.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | payload_byte, last_byte
//  out     | out_valid / out_stall| status, proto_version, relays_txs,
//          |                      | offer_allowed
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One byte is taken per cycle while in_stall is low; the parse state registers take each byte.
//  A last byte's result is registered in the output register, valid in the cycle after it.
//  Input stalls only while a result sits in the output register and is stalled.
//  rst is synchronous: parse state clears; config registers and out_valid return to defaults.
//  cfg_ready is always high; a write goes straight into its config register.
`default_nettype none

module version_payload_relay_offer_check (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    payload_byte,
  input  wire logic                          last_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               status,
  output logic [31:0]                        proto_version,
  output logic                               relays_txs,
  output logic                               offer_allowed,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [vpr_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [vpr_pkg::CfgDataW-1:0]  cfg_data
);
  import vpr_pkg::*;

  // Configuration registers
  logic [MinVerW-1:0] min_proto_version;
  logic               block_relay_only;
  logic               feeler_conn;
  logic               addr_fetch_conn;
  logic               ignore_incoming_txs;

  // Parse state
  phase_t           parse_phase, parse_phase_next;
  logic [PosW-1:0]  byte_position, byte_position_next;
  logic [VerW-1:0]  version_word, version_word_next;
  logic [LenW-1:0]  agent_length, agent_length_next;
  relay_t           relay_seen, relay_seen_next;

  logic             in_take;
  logic             res_ok, res_relays, res_offer;
  logic [VerW-1:0]  res_version;
  logic [LenW-1:0]  len_dec;
  logic [LenW-1:0]  ext_len;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign len_dec   = agent_length - LenW'(1);
  assign ext_len   = {payload_byte, agent_length[7:0]};

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_proto_version   <= MIN_VERSION_RESET;
      block_relay_only    <= 1'b0;
      feeler_conn         <= 1'b0;
      addr_fetch_conn     <= 1'b0;
      ignore_incoming_txs <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_PROTO_VERSION:   min_proto_version   <= cfg_data[MinVerW-1:0];
        CFG_BLOCK_RELAY_ONLY:    block_relay_only    <= cfg_data[0];
        CFG_FEELER_CONN:         feeler_conn         <= cfg_data[0];
        CFG_ADDR_FETCH_CONN:     addr_fetch_conn     <= cfg_data[0];
        CFG_IGNORE_INCOMING_TXS: ignore_incoming_txs <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Byte walk: next parse state for the incoming byte
  always_comb begin
    parse_phase_next  = parse_phase;
    version_word_next = version_word;
    agent_length_next = agent_length;
    relay_seen_next   = relay_seen;
    byte_position_next = (byte_position != POS_MAX) ? byte_position + PosW'(1)
                                                    : byte_position;
    case (parse_phase)
      PH_HEADER: begin
        if (byte_position < POS_VER_DONE) begin
          version_word_next[8*byte_position[1:0] +: 8] =
            version_word[8*byte_position[1:0] +: 8] | payload_byte;
        end
        if (byte_position >= POS_LAST_HEADER) parse_phase_next = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (payload_byte < LEN_PREFIX_16) begin
          if (payload_byte == 8'd0) begin
            parse_phase_next  = PH_HEIGHT;
            agent_length_next = HEIGHT_LEN;
          end else begin
            parse_phase_next  = PH_AGENT;
            agent_length_next = LenW'(payload_byte);
          end
        end else if (payload_byte == LEN_PREFIX_16) begin
          agent_length_next = '0;
          parse_phase_next  = PH_EXT;
        end else begin
          parse_phase_next = PH_BAD;
        end
      end
      PH_EXT: begin
        if (byte_position == POS_EXT_LOW) begin
          agent_length_next = LenW'(payload_byte);
        end else if (ext_len == '0) begin
          parse_phase_next  = PH_HEIGHT;
          agent_length_next = HEIGHT_LEN;
        end else begin
          parse_phase_next  = PH_AGENT;
          agent_length_next = ext_len;
        end
      end
      PH_AGENT: begin
        if (len_dec == '0) begin
          parse_phase_next  = PH_HEIGHT;
          agent_length_next = HEIGHT_LEN;
        end else begin
          agent_length_next = len_dec;
        end
      end
      PH_HEIGHT: begin
        agent_length_next = len_dec;
        if (len_dec == '0) parse_phase_next = PH_RELAY;
      end
      PH_RELAY: begin
        relay_seen_next  = (payload_byte != 8'd0) ? RELAY_NONZERO : RELAY_ZERO;
        parse_phase_next = PH_DONE;
      end
      default: ;
    endcase
  end

  // Result for a last byte, taken from the updated state
  always_comb begin
    res_ok      = (parse_phase_next == PH_RELAY) || (parse_phase_next == PH_DONE);
    res_version = (byte_position_next >= POS_VER_DONE) ? version_word_next : '0;
    if (!res_ok)                          res_relays = 1'b0;
    else if (parse_phase_next == PH_DONE) res_relays = (relay_seen_next == RELAY_NONZERO);
    else                                  res_relays = 1'b1;
    res_offer = res_ok && res_relays && !res_version[VerW-1] &&
                (res_version[MinVerW-1:0] >= min_proto_version) &&
                !block_relay_only && !feeler_conn && !addr_fetch_conn &&
                !ignore_incoming_txs;
  end

  // Parse state registers; a last byte restarts the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_HEADER;
      byte_position <= '0;
      version_word  <= '0;
      agent_length  <= '0;
      relay_seen    <= RELAY_ABSENT;
    end else if (in_take) begin
      if (last_byte) begin
        parse_phase   <= PH_HEADER;
        byte_position <= '0;
        version_word  <= '0;
        agent_length  <= '0;
        relay_seen    <= RELAY_ABSENT;
      end else begin
        parse_phase   <= parse_phase_next;
        byte_position <= byte_position_next;
        version_word  <= version_word_next;
        agent_length  <= agent_length_next;
        relay_seen    <= relay_seen_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && last_byte) begin
      status        <= !res_ok;
      proto_version <= res_version;
      relays_txs    <= res_relays;
      offer_allowed <= res_offer;
    end
  end

  // Checks
  a_last_gives_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last_byte) |=> out_valid)
    else $error("last byte accepted but no result word");

  a_no_spurious_word: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !(in_valid && !in_stall && last_byte)) |=> !out_valid)
    else $error("result word without a last byte");

  a_offer_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && offer_allowed) |-> (!status && relays_txs))
    else $error("offer on malformed or non-relaying payload");

  a_bad_no_relay: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> !relays_txs)
    else $error("relay flag set on malformed payload");

endmodule

`default_nettype wire
